// ----- design/lwsra_pkg.sv -----
// Shared types, constants and level window tables for the launcher wheel speed ramp.
package lwsra_pkg;

  localparam int CORR_BITS  = 10;
  localparam int BASE_BITS  = 14;
  localparam int STEP_BITS  = 10;
  localparam int READ_BITS  = 10;
  localparam int SHOT_BITS  = 8;
  localparam int LVL_BITS   = 2;
  localparam int NUM_LEVELS = 3;
  localparam int CNT_BITS   = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;

  typedef logic signed [CORR_BITS-1:0] corr_t;
  typedef logic [LVL_BITS-1:0]         level_t;
  typedef logic [READ_BITS-1:0]        reading_t;
  typedef logic [CNT_BITS-1:0]         low_cnt_t;

  localparam corr_t    CORR_MAX   = 10'sd511;
  localparam corr_t    CORR_MIN   = -10'sd512;
  localparam reading_t STOP_LIMIT = 10'd100;
  localparam low_cnt_t LOW_RUN    = 3'd4;

  // Speed level codes.
  localparam level_t LEVEL_NONE = 2'd0;
  localparam level_t LEVEL_1    = 2'd1;
  localparam level_t LEVEL_2    = 2'd2;
  localparam level_t LEVEL_3    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEP   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SNAP_WINDOW = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_SPEED  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_L1     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_L2     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_L3     = 3'd5;

  // Request from the top level into the adaptation unit for one tick.
  typedef struct packed {
    logic                 referee_ok;
    logic [SHOT_BITS-1:0] shot_count;
    reading_t             shot_speed;
    level_t               held_level;
  } adapt_req_t;

  // Adaptation result: stop flag and corrections after this tick.
  typedef struct packed {
    logic                        stop;
    corr_t [NUM_LEVELS-1:0]      corr;
  } adapt_res_t;

  // Muzzle speed window per level in 0.1 m/s, indexed by level minus one.
  function automatic reading_t win_low(input logic [1:0] idx);
    reading_t v;
    case (idx)
      2'd0:    v = 10'd140;
      2'd1:    v = 10'd170;
      default: v = 10'd282;
    endcase
    return v;
  endfunction

  function automatic reading_t win_high(input logic [1:0] idx);
    reading_t v;
    case (idx)
      2'd0:    v = 10'd148;
      2'd1:    v = 10'd178;
      default: v = 10'd297;
    endcase
    return v;
  endfunction

endpackage

// ----- design/launcher_wheel_speed_ramp_adapt_top.sv -----
// Top level of the launcher wheel speed ramp with learned per-level correction.
//
//   Channel  Direction  Handshake            Contents
//   in_      request    in_valid / in_stall  enable, link flags, level, shot count, speed
//   out_     result     out_valid/out_stall  wheel speed, target, stop request, level
//   cfg_     write      cfg_valid/cfg_ready  register index and write data
//
// One request is taken per cycle unless a stalled result holds it; its result is registered.
// Throughput is set by the single feedback pass from the held wheel speed through the
// target select, ramp step and snap compare back into the speed register.
// Synchronous active-low reset clears valid, speed, level and learnt state; loads defaults.
// A stalled result holds the pipeline: the input register waits, and in_stall rises if full.
module launcher_wheel_speed_ramp_adapt_top #(
  parameter int SPEED_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_wheel_enable,
  input  logic                                in_remote_ok,
  input  logic                                in_referee_ok,
  input  logic [1:0]                          in_speed_level,
  input  logic [7:0]                          in_shot_count,
  input  logic [9:0]                          in_shot_speed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SPEED_BITS-1:0]        out_wheel_speed,
  output logic signed [SPEED_BITS-1:0]        out_target_speed,
  output logic                                out_stop_request,
  output logic [1:0]                          out_level_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lwsra_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lwsra_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import lwsra_pkg::*;

  // Working width covers base plus correction and speed plus one ramp step.
  localparam int W = (SPEED_BITS > 15) ? SPEED_BITS + 3 : 18;
  localparam logic signed [W-1:0] SPD_MAX_W = W'((1 <<< (SPEED_BITS - 1)) - 1);
  localparam logic signed [W-1:0] SPD_MIN_W = -SPD_MAX_W - W'(1);

  // Configuration registers.
  logic [STEP_BITS-1:0] ramp_step_r, snap_window_r;
  logic [BASE_BITS-1:0] stop_speed_r, base_l1_r, base_l2_r, base_l3_r;

  // Input register.
  logic                 in_vld_r;
  logic                 en_r, rc_r, ref_r;
  level_t               lvl_r;
  logic [SHOT_BITS-1:0] shots_r;
  reading_t             sspeed_r;

  // State and result registers.
  logic signed [SPEED_BITS-1:0] speed_now_r, speed_nxt;
  level_t                       held_level_r, held_nxt;
  logic signed [SPEED_BITS-1:0] target_r, target_nxt;
  logic                         stop_r;
  logic                         out_vld_r;

  logic       adv, take_in;
  adapt_req_t areq;
  adapt_res_t ares;

  logic signed [W-1:0] tgt_w, tgt_c, spd_w, s1, s2, diff, dabs, step_w, spd_c;
  corr_t               corr_sel;
  logic [BASE_BITS-1:0] base_sel;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign take_in  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r   <= 10'd80;
      snap_window_r <= 10'd100;
      stop_speed_r  <= 14'd0;
      base_l1_r     <= 14'd4000;
      base_l2_r     <= 14'd4500;
      base_l3_r     <= 14'd7000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RAMP_STEP:   ramp_step_r   <= cfg_data[STEP_BITS-1:0];
        REG_SNAP_WINDOW: snap_window_r <= cfg_data[STEP_BITS-1:0];
        REG_STOP_SPEED:  stop_speed_r  <= cfg_data;
        REG_BASE_L1:     base_l1_r     <= cfg_data;
        REG_BASE_L2:     base_l2_r     <= cfg_data;
        REG_BASE_L3:     base_l3_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take_in) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      en_r     <= in_wheel_enable;
      rc_r     <= in_remote_ok;
      ref_r    <= in_referee_ok;
      lvl_r    <= in_speed_level;
      shots_r  <= in_shot_count;
      sspeed_r <= in_shot_speed;
    end
  end

  always_comb begin
    areq.referee_ok = ref_r;
    areq.shot_count = shots_r;
    areq.shot_speed = sspeed_r;
    areq.held_level = held_level_r;
  end

  lwsra_adapt u_adapt (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .req   (areq),
    .res   (ares)
  );

  // Target select, then one ramp step with snap onto the target.
  always_comb begin
    held_nxt = (en_r && rc_r && ref_r) ? lvl_r : held_level_r;

    base_sel = base_l1_r;
    corr_sel = '0;
    case (held_nxt)
      LEVEL_2: begin
        base_sel = base_l2_r;
        corr_sel = ares.corr[1];
      end
      LEVEL_3: begin
        base_sel = base_l3_r;
        corr_sel = ares.corr[2];
      end
      default: begin
        base_sel = base_l1_r;
        corr_sel = ares.corr[0];
      end
    endcase

    if (!en_r || !rc_r) begin
      tgt_w = W'(stop_speed_r);
    end else if (!ref_r || (held_nxt == LEVEL_NONE)) begin
      tgt_w = W'(base_l1_r);
    end else begin
      tgt_w = W'(base_sel) + {{(W-CORR_BITS){corr_sel[CORR_BITS-1]}}, corr_sel};
    end

    if (tgt_w > SPD_MAX_W) begin
      tgt_c = SPD_MAX_W;
    end else if (tgt_w < SPD_MIN_W) begin
      tgt_c = SPD_MIN_W;
    end else begin
      tgt_c = tgt_w;
    end
    target_nxt = tgt_c[SPEED_BITS-1:0];

    step_w = W'(ramp_step_r);
    spd_w  = {{(W-SPEED_BITS){speed_now_r[SPEED_BITS-1]}}, speed_now_r};
    s1     = (spd_w > tgt_c) ? spd_w - step_w : spd_w;
    // A value below the target, after a downward step or none, is stepped up by one step.
    s2     = (s1 < tgt_c) ? s1 + step_w : s1;
    diff   = s2 - tgt_c;
    dabs   = diff[W-1] ? -diff : diff;

    if (dabs < W'(snap_window_r)) begin
      spd_c = tgt_c;
    end else if (s2 > SPD_MAX_W) begin
      spd_c = SPD_MAX_W;
    end else if (s2 < SPD_MIN_W) begin
      spd_c = SPD_MIN_W;
    end else begin
      spd_c = s2;
    end
    speed_nxt = spd_c[SPEED_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_now_r  <= '0;
      held_level_r <= LEVEL_NONE;
      out_vld_r    <= 1'b0;
    end else begin
      if (adv) begin
        speed_now_r  <= speed_nxt;
        held_level_r <= held_nxt;
        out_vld_r    <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      target_r <= target_nxt;
      stop_r   <= ares.stop;
    end
  end

  // Held speed and level change only together with a new result.
  assign out_valid        = out_vld_r;
  assign out_wheel_speed  = speed_now_r;
  assign out_target_speed = target_r;
  assign out_stop_request = stop_r;
  assign out_level_now    = held_level_r;

`ifndef SYNTHESIS
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("result register not loaded after advance");

  a_blocked_item_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_vld_r && out_stall) |-> in_stall)
    else $error("input not stalled while result is blocked");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(speed_now_r) && $stable(held_level_r)))
    else $error("state changed without an advancing request");

  a_stop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ares.stop) |-> (ref_r && (held_level_r != LEVEL_NONE)))
    else $error("stop request without a usable reading");
`endif

endmodule

// ----- design/lwsra_adapt.sv -----
// Per-level speed correction learning from muzzle speed readings.
module lwsra_adapt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  lwsra_pkg::adapt_req_t  req,
  output lwsra_pkg::adapt_res_t  res
);
  import lwsra_pkg::*;

  corr_t [NUM_LEVELS-1:0]   corr_r, corr_nxt;
  low_cnt_t                 low_cnt_r, low_cnt_nxt;
  logic [SHOT_BITS-1:0]     last_shot_r, last_shot_nxt;

  logic        new_rd, adapt_go, is_low, in_win, is_high;
  logic [1:0]  idx;
  reading_t    lo, hi;
  low_cnt_t    cnt_inc;
  logic signed [CORR_BITS:0] sum_up, sum_dn;

  always_comb begin
    new_rd   = req.referee_ok && (req.shot_count != last_shot_r);
    adapt_go = new_rd && (req.held_level != LEVEL_NONE);
    idx      = req.held_level - 2'd1;
    lo       = win_low(idx);
    hi       = win_high(idx);
    is_low   = (req.shot_speed < lo) && (req.shot_speed > STOP_LIMIT);
    in_win   = (req.shot_speed >= lo) && (req.shot_speed <= hi);
    is_high  = req.shot_speed > hi;
    cnt_inc  = low_cnt_r + 3'd1;

    last_shot_nxt = new_rd ? req.shot_count : last_shot_r;
    low_cnt_nxt   = low_cnt_r;
    corr_nxt      = corr_r;
    sum_up        = '0;
    sum_dn        = '0;

    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (adapt_go && (idx == 2'(i))) begin
        sum_up = {corr_r[i][CORR_BITS-1], corr_r[i]} + 11'sd1;
        sum_dn = {corr_r[i][CORR_BITS-1], corr_r[i]} - 11'sd2;
        if (is_low) begin
          if (cnt_inc >= LOW_RUN) begin
            low_cnt_nxt = '0;
            corr_nxt[i] = (sum_up > 11'sd511) ? CORR_MAX : sum_up[CORR_BITS-1:0];
          end else begin
            low_cnt_nxt = cnt_inc;
          end
        end else if (in_win) begin
          low_cnt_nxt = '0;
        end
        if (is_high) begin
          corr_nxt[i] = (sum_dn < -11'sd512) ? CORR_MIN : sum_dn[CORR_BITS-1:0];
        end
      end
    end

    res.stop = adapt_go && (req.shot_speed < STOP_LIMIT);
    res.corr = corr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_r      <= '0;
      low_cnt_r   <= '0;
      last_shot_r <= '0;
    end else if (adv) begin
      corr_r      <= corr_nxt;
      low_cnt_r   <= low_cnt_nxt;
      last_shot_r <= last_shot_nxt;
    end
  end

endmodule
